// File: hw/rtl/alp_pkg.sv
// ============================================================================
// Lat/lon field parser package
// Shared widths, character codes and types for the coordinate field parser.
// ============================================================================
package alp_pkg;

    // Window geometry: a full window and the captured part of it.
    localparam int WIN_LEN = 20;
    localparam int CAP_LEN = 19;

    // Default record length limit in bytes.
    localparam int MAX_RECORD_BYTES_DEF = 160;

    // Result field widths.
    localparam int LAT_W = 27;
    localparam int LON_W = 30;
    localparam int LAT_MAG_W = 26;
    localparam int LON_MAG_W = 29;

    // Stream payload widths.
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // Character codes.
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    typedef logic [7:0] byte_t;
    typedef byte_t cap_bytes_t [CAP_LEN];

    // Control from the window chain to the decoder.
    typedef struct packed {
        logic load;   // last item of a record accepted
        logic any;    // a window was chosen
    } sel_ctrl_t;

    function automatic logic is_digit(input byte_t c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Digit value; a non-digit counts as zero.
    function automatic logic [3:0] digit_val(input byte_t c);
        byte_t d;
        d = c - CH_0;
        return is_digit(c) ? d[3:0] : 4'd0;
    endfunction

endpackage

// File: hw/rtl/alp_cell.sv
// ============================================================================
// Window cell
// One byte of the sliding window plus the matching north and south capture
// bytes; shifts toward the window start and captures on request.
// ============================================================================
module alp_cell
    import alp_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  byte_t shift_in,
    input  logic  cap_north,
    input  logic  cap_south,
    output byte_t byte_q,
    output byte_t north_q,
    output byte_t south_q
);

    byte_t byte_reg;
    byte_t north_reg;
    byte_t south_reg;

    // The captures take the value this cell holds after the shift.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= shift_in;
        end
        if (cap_north)
        begin
            north_reg <= shift_in;
        end
        if (cap_south)
        begin
            south_reg <= shift_in;
        end
    end

    assign byte_q  = byte_reg;
    assign north_q = north_reg;
    assign south_q = south_reg;

endmodule

// File: hw/rtl/alp_window.sv
// ============================================================================
// Sliding window chain
// A row of window cells with byte counting, window matching and selection
// of the captured window at the end of a record.
// ============================================================================
module alp_window
    import alp_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  byte_t      data_byte,
    input  logic       is_last,
    output cap_bytes_t sel_bytes,
    output sel_ctrl_t  sel_ctrl
);

    localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             north_reg;
    logic             north_next;
    logic             south_reg;
    logic             south_next;
    byte_t            head_reg;

    logic  shift_en;
    logic  match;
    logic  cap_north;
    logic  cap_south;
    byte_t shift_in  [CAP_LEN];
    byte_t cell_byte [CAP_LEN];
    byte_t cell_north[CAP_LEN];
    byte_t cell_south[CAP_LEN];

    // Bytes past the record limit are dropped.
    assign shift_en = accept && (count_reg < CNT_W'(MAX_RECORD_BYTES));

    // Each cell takes its right neighbor; the head takes the new byte.
    always_comb
    begin
        for (int k = 0; k < CAP_LEN; k++)
        begin
            shift_in[k] = (k == CAP_LEN - 1) ? head_reg : cell_byte[(k + 1) % CAP_LEN];
        end
    end

    // Test the window as it stands after this shift.
    assign match = shift_en && (count_reg >= CNT_W'(CAP_LEN))
                   && ((shift_in[9] == CH_W) || (shift_in[9] == CH_E));
    assign cap_north = match && (shift_in[0] == CH_N) && !north_reg;
    assign cap_south = match && (shift_in[0] == CH_S) && !south_reg;

    genvar g;
    generate
        for (g = 0; g < CAP_LEN; g++)
        begin : g_cell
            alp_cell u_cell (
                .clk       (clk),
                .shift_en  (shift_en),
                .shift_in  (shift_in[g]),
                .cap_north (cap_north),
                .cap_south (cap_south),
                .byte_q    (cell_byte[g]),
                .north_q   (cell_north[g]),
                .south_q   (cell_south[g])
            );
        end
    endgenerate

    // Head of the chain holds the newest byte.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            head_reg <= data_byte;
        end
    end

    // Counters and found flags; the end of a record clears them.
    always_comb
    begin
        count_next = count_reg;
        north_next = north_reg || cap_north;
        south_next = south_reg || cap_south;
        if (shift_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (accept && is_last)
        begin
            count_next = '0;
            north_next = 1'b0;
            south_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            north_reg <= 1'b0;
            south_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            north_reg <= north_next;
            south_reg <= south_next;
        end
    end

    // North wins over south; a capture made this cycle comes from the window.
    always_comb
    begin
        for (int k = 0; k < CAP_LEN; k++)
        begin
            if (north_reg)
            begin
                sel_bytes[k] = cell_north[k];
            end
            else if (cap_north)
            begin
                sel_bytes[k] = shift_in[k];
            end
            else if (south_reg)
            begin
                sel_bytes[k] = cell_south[k];
            end
            else
            begin
                sel_bytes[k] = shift_in[k];
            end
        end
    end

    assign sel_ctrl.load = accept && is_last;
    assign sel_ctrl.any  = north_reg || south_reg || cap_north || cap_south;

endmodule

// File: hw/rtl/alp_decode.sv
// ============================================================================
// Coordinate decoder
// Three-stage pipeline: window register, digit conversion, then scaling,
// sign and the output register, with per-stage flow control.
// ============================================================================
module alp_decode
    import alp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cap_bytes_t            sel_bytes,
    input  sel_ctrl_t             sel_ctrl,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic                  bad_digit,
    output logic signed [LAT_W-1:0] lat_value,
    output logic signed [LON_W-1:0] lon_value
);

    // Stage valid bits.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic ov_reg, ov_next;
    logic out_go;
    logic can2;
    logic load2;

    // Stage 1 payload.
    byte_t win_reg [CAP_LEN];
    logic  any1_reg;

    // Stage 2 payload.
    logic [6:0]  lat_deg_reg;
    logic [6:0]  lat_min_reg;
    logic [13:0] lat_sec_reg;
    logic [9:0]  lon_deg_reg;
    logic [6:0]  lon_min_reg;
    logic [13:0] lon_sec_reg;
    logic        neg_lat_reg;
    logic        neg_lon_reg;
    logic        any2_reg;
    logic        bad2_reg;

    // Output payload.
    logic                    found_reg;
    logic                    bad_reg;
    logic [LAT_W-1:0]        lat_reg;
    logic [LON_W-1:0]        lon_reg;

    logic [3:0]           d [CAP_LEN];
    logic                 bad_any;
    logic [LAT_MAG_W-1:0] lat_mag;
    logic [LON_MAG_W-1:0] lon_mag;
    logic [LAT_W-1:0]     lat_next;
    logic [LON_W-1:0]     lon_next;

    // Flow control: a stage moves when the next one is empty or moving.
    assign out_go   = v2_reg && (!ov_reg || out_ready);
    assign can2     = !v2_reg || out_go;
    assign in_ready = !v1_reg || can2;
    assign load2    = v1_reg && can2;

    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        ov_next = ov_reg;
        if (sel_ctrl.load)
        begin
            v1_next = 1'b1;
        end
        else if (can2)
        begin
            v1_next = 1'b0;
        end
        if (load2)
        begin
            v2_next = 1'b1;
        end
        else if (out_go)
        begin
            v2_next = 1'b0;
        end
        if (out_go)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            ov_reg <= ov_next;
        end
    end

    // Stage 1: hold the chosen window.
    always_ff @(posedge clk)
    begin
        if (sel_ctrl.load)
        begin
            win_reg  <= sel_bytes;
            any1_reg <= sel_ctrl.any;
        end
    end

    // Digit values and the check of every digit position.
    always_comb
    begin
        bad_any = 1'b0;
        for (int k = 0; k < CAP_LEN; k++)
        begin
            d[k] = digit_val(win_reg[k]);
            if ((k != 0) && (k != 9) && !is_digit(win_reg[k]))
            begin
                bad_any = 1'b1;
            end
        end
    end

    // Stage 2: decimal fields in binary.
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            lat_deg_reg <= 7'(d[1]) * 7'd10 + 7'(d[2]);
            lat_min_reg <= 7'(d[3]) * 7'd10 + 7'(d[4]);
            lat_sec_reg <= 14'(d[5]) * 14'd1000 + 14'(d[6]) * 14'd100
                           + 14'(d[7]) * 14'd10 + 14'(d[8]);
            lon_deg_reg <= 10'(d[10]) * 10'd100 + 10'(d[11]) * 10'd10 + 10'(d[12]);
            lon_min_reg <= 7'(d[13]) * 7'd10 + 7'(d[14]);
            lon_sec_reg <= 14'(d[15]) * 14'd1000 + 14'(d[16]) * 14'd100
                           + 14'(d[17]) * 14'd10 + 14'(d[18]);
            neg_lat_reg <= (win_reg[0] == CH_S);
            neg_lon_reg <= (win_reg[9] == CH_W);
            any2_reg    <= any1_reg;
            bad2_reg    <= any1_reg && bad_any;
        end
    end

    // Scale to hundredths of an arcsecond and apply the hemisphere sign.
    assign lat_mag = LAT_MAG_W'(lat_deg_reg) * LAT_MAG_W'(360000)
                   + LAT_MAG_W'(lat_min_reg) * LAT_MAG_W'(6000)
                   + LAT_MAG_W'(lat_sec_reg);
    assign lon_mag = LON_MAG_W'(lon_deg_reg) * LON_MAG_W'(360000)
                   + LON_MAG_W'(lon_min_reg) * LON_MAG_W'(6000)
                   + LON_MAG_W'(lon_sec_reg);

    always_comb
    begin
        lat_next = neg_lat_reg ? (LAT_W'(0) - LAT_W'(lat_mag)) : LAT_W'(lat_mag);
        lon_next = neg_lon_reg ? (LON_W'(0) - LON_W'(lon_mag)) : LON_W'(lon_mag);
        if (!any2_reg || bad2_reg)
        begin
            lat_next = '0;
            lon_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_go)
        begin
            found_reg <= any2_reg && !bad2_reg;
            bad_reg   <= bad2_reg;
            lat_reg   <= lat_next;
            lon_reg   <= lon_next;
        end
    end

    assign out_valid = ov_reg;
    assign found     = found_reg;
    assign bad_digit = bad_reg;
    assign lat_value = lat_reg;
    assign lon_value = lon_reg;

endmodule

// File: hw/rtl/arinc_latlon_field_parser.sv
// ============================================================================
// Lat/lon field parser
// Scans record text for a hDDMMSSSShDDDMMSSSS coordinate window and reports
// latitude and longitude in hundredths of an arcsecond at the record end.
// ============================================================================
//
// Channel   Dir  Payload                                   Items
// s_axis    in   tdata = data_byte[7:0], tlast = is_last   one per text byte
// m_axis    out  tuser = found, bad_digit; tdata = lat,lon one per record
//
// Every cycle one byte can be taken while the first stage is free; the window
// chain shifts once per item below the record limit. After the last byte of its
// record, a result passes the window register, digit conversion and scaling stages.
// Reset clears the byte count, the found flags and all stage valid bits.
// A stalled result stops only the stages behind it; bytes keep flowing while
// the first stage is free.
//
module arinc_latlon_field_parser
    import alp_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // is_last
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [26:0] lat_value, [56:27] lon_value
    output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] found, [1] bad_digit
);

    logic       accept;
    cap_bytes_t sel_bytes;
    sel_ctrl_t  sel_ctrl;
    logic       found;
    logic       bad_digit;
    logic signed [LAT_W-1:0] lat_value;
    logic signed [LON_W-1:0] lon_value;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Window chain with capture and selection.
    alp_window #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_axis_tdata),
        .is_last   (s_axis_tlast),
        .sel_bytes (sel_bytes),
        .sel_ctrl  (sel_ctrl)
    );

    // Digit conversion and output pipeline.
    alp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_bytes (sel_bytes),
        .sel_ctrl  (sel_ctrl),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .found     (found),
        .bad_digit (bad_digit),
        .lat_value (lat_value),
        .lon_value (lon_value)
    );

    // Pack the result item.
    assign m_axis_tdata = {{(OUT_DATA_W - LAT_W - LON_W){1'b0}}, lon_value, lat_value};
    assign m_axis_tuser = {bad_digit, found};

endmodule

// File: bench/arinc_latlon_field_parser_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Lat/lon field parser checker
// Watches both stream channels of the parser, keeps its own copy of the
// window and capture state, works out the coordinate result at every record
// end and compares each result item with the oldest one still owed.
// ============================================================================
module arinc_latlon_field_parser_checker
    import alp_pkg::*;
#(
    parameter int RECORD_LIMIT = MAX_RECORD_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // is_last
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [26:0] lat_value, [56:27] lon_value
    input  logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] found, [1] bad_digit
    output int                    mismatches,
    output int                    outstanding
);

    // Positions inside a window.
    localparam int LAT_HEMI_POS = 0;
    localparam int LON_HEMI_POS = 9;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                    found;
        logic                    bad_digit;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } coord_result_t;

    byte_t         win_bytes [WIN_LEN];
    int unsigned   taken_bytes;
    logic          north_seen;
    logic          south_seen;
    byte_t         north_win [CAP_LEN];
    byte_t         south_win [CAP_LEN];
    coord_result_t owed_coords [$];
    int            result_index;

    // Decimal value of n characters from pos; non-digits are caught elsewhere.
    function automatic int unsigned decimal_at(input byte_t w [CAP_LEN], input int pos,
                                               input int n);
        int unsigned v;
        v = 0;
        for (int k = 0; k < n; k++)
            v = v * 10 + int'(w[pos + k] - CH_0);
        return v;
    endfunction

    // Turn a captured window into the coordinate pair.
    function automatic coord_result_t decode_window(input byte_t w [CAP_LEN]);
        coord_result_t r;
        logic          bad;
        logic [31:0]   lat_mag;
        logic [31:0]   lon_mag;
        logic [31:0]   lat_full;
        logic [31:0]   lon_full;
        r = '0;
        bad = 1'b0;
        for (int i = 1; i < CAP_LEN; i++)
            if (i != LON_HEMI_POS && (w[i] < CH_0 || w[i] > CH_9))
                bad = 1'b1;
        lat_mag = decimal_at(w, 1, 2) * 360000 + decimal_at(w, 3, 2) * 6000
                + decimal_at(w, 5, 4);
        lon_mag = decimal_at(w, 10, 3) * 360000 + decimal_at(w, 13, 2) * 6000
                + decimal_at(w, 15, 4);
        if (bad)
        begin
            r.bad_digit = 1'b1;
        end
        else
        begin
            lat_full = (w[LAT_HEMI_POS] == CH_S) ? 32'd0 - lat_mag : lat_mag;
            lon_full = (w[LON_HEMI_POS] == CH_W) ? 32'd0 - lon_mag : lon_mag;
            r.found = 1'b1;
            r.lat = lat_full[LAT_W-1:0];
            r.lon = lon_full[LON_W-1:0];
        end
        return r;
    endfunction

    function automatic void clear_record();
        foreach (win_bytes[i])
            win_bytes[i] = '0;
        taken_bytes = 0;
        north_seen = 1'b0;
        south_seen = 1'b0;
    endfunction

    // Shift one text byte into the window and close the record on its last byte.
    function automatic void take_byte(input byte_t b, input logic last);
        coord_result_t r;
        if (taken_bytes < RECORD_LIMIT)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                win_bytes[i] = win_bytes[i + 1];
            win_bytes[WIN_LEN - 1] = b;
            taken_bytes++;
            if (taken_bytes >= WIN_LEN &&
                (win_bytes[LON_HEMI_POS] == CH_W || win_bytes[LON_HEMI_POS] == CH_E))
            begin
                if (win_bytes[LAT_HEMI_POS] == CH_N && !north_seen)
                begin
                    for (int i = 0; i < CAP_LEN; i++)
                        north_win[i] = win_bytes[i];
                    north_seen = 1'b1;
                end
                else if (win_bytes[LAT_HEMI_POS] == CH_S && !south_seen)
                begin
                    for (int i = 0; i < CAP_LEN; i++)
                        south_win[i] = win_bytes[i];
                    south_seen = 1'b1;
                end
            end
        end
        if (last)
        begin
            r = '0;
            if (north_seen)
                r = decode_window(north_win);
            else if (south_seen)
                r = decode_window(south_win);
            owed_coords.insert(owed_coords.size(), r);
            clear_record();
        end
    endfunction

    // Compare one result item with the oldest owed result.
    function automatic void check_result();
        coord_result_t got;
        coord_result_t want;
        got.found = m_axis_tuser[0];
        got.bad_digit = m_axis_tuser[1];
        got.lat = m_axis_tdata[LAT_W-1:0];
        got.lon = m_axis_tdata[LAT_W+LON_W-1:LAT_W];
        if (owed_coords.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d not owed: found=%0b bad=%0b lat=%0d lon=%0d",
                         result_index, got.found, got.bad_digit,
                         $signed(got.lat), $signed(got.lon));
        end
        else
        begin
            want = owed_coords.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $write("result %0d mismatch: expected found=%0b bad=%0b lat=%0d lon=%0d",
                           result_index, want.found, want.bad_digit,
                           $signed(want.lat), $signed(want.lon));
                    $display(", got found=%0b bad=%0b lat=%0d lon=%0d",
                             got.found, got.bad_digit, $signed(got.lat), $signed(got.lon));
                end
            end
        end
        result_index++;
    endfunction

    // Follow both channels at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_record();
            owed_coords.delete();
            mismatches = 0;
            result_index = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            outstanding <= owed_coords.size();
        end
    end

endmodule

// File: bench/arinc_latlon_field_parser_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Lat/lon field parser testbench
// Streams record text into the parser: a few directed records, then random
// records that are mostly well formed coordinate windows, mixed with noise,
// short, near-miss and overlong records, under random idling on both sides.
// ============================================================================
module arinc_latlon_field_parser_test;
    import alp_pkg::*;

    localparam int TARGET_ITEMS = 600;
    localparam int MIN_RECORDS = 36;
    localparam int MAX_GAP = 17;
    localparam int LONG_HOLD = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 20;
    localparam byte_t CH_SP = 8'h20;
    localparam byte_t CH_A = 8'h41;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int   mismatches;
    int   outstanding;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   out_wait = 1;
    bit   out_fast = 1'b0;
    int   quiet_cycles = 0;
    int   sent_items = 0;
    int   sent_records = 0;

    arinc_latlon_field_parser uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    arinc_latlon_field_parser_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #1 clk = ~clk;

    // Result side: random hold-offs after each item, fast stretches, and one
    // long hold when the stimulus asks for it.
    always @(posedge clk)
    begin : result_side
        int gap;
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            out_wait <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (m_axis_tready && m_axis_tvalid)
        begin
            if ($urandom_range(0, 7) == 0)
                out_fast = !out_fast;
            gap = out_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                out_wait <= gap;
            end
        end
        else if (!m_axis_tready)
        begin
            if (out_wait <= 1)
                m_axis_tready <= 1'b1;
            else
                out_wait <= out_wait - 1;
        end
    end

    // Watchdog on cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic byte_t random_digit();
        return CH_0 + byte_t'($urandom_range(0, 9));
    endfunction

    function automatic byte_t random_non_digit();
        byte_t c;
        do
            c = byte_t'($urandom_range(0, 255));
        while (c >= CH_0 && c <= CH_9);
        return c;
    endfunction

    // Plain record text: spaces, capitals and digits.
    function automatic byte_t random_filler();
        byte_t c;
        case ($urandom_range(0, 2))
            0: c = CH_SP;
            1: c = CH_A + byte_t'($urandom_range(0, 25));
            default: c = random_digit();
        endcase
        return c;
    endfunction

    function automatic byte_t random_lat_hemi();
        return $urandom_range(0, 1) ? CH_N : CH_S;
    endfunction

    function automatic byte_t random_lon_hemi();
        return $urandom_range(0, 1) ? CH_W : CH_E;
    endfunction

    task automatic add_filler(ref byte_t rec [$], input int n);
        repeat (n)
            rec.insert(rec.size(), random_filler());
    endtask

    // Append a full 20-byte window; spoil puts a non-digit in a digit position.
    task automatic add_window(ref byte_t rec [$], input byte_t lat_h, input byte_t lon_h,
                              input bit spoil);
        byte_t w [WIN_LEN];
        int    style;
        int    p;
        style = $urandom_range(0, 9);
        w[0] = lat_h;
        w[9] = lon_h;
        for (int i = 1; i < WIN_LEN; i++)
            if (i != 9)
                w[i] = (style == 0) ? CH_9 : (style == 1) ? CH_0 : random_digit();
        if (spoil)
        begin
            p = $urandom_range(1, 17);
            if (p >= 9)
                p++;
            w[p] = random_non_digit();
        end
        foreach (w[i])
            rec.insert(rec.size(), w[i]);
    endtask

    // Offer one item after a gap; returns at the edge where it is taken.
    task automatic send_byte(input byte_t b, input logic last, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_record(ref byte_t rec [$], input bit no_gaps);
        for (int i = 0; i < rec.size(); i++)
            send_byte(rec[i], i == rec.size() - 1, no_gaps ? 0 : $urandom_range(0, MAX_GAP));
        sent_items += rec.size();
        sent_records++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Build one random record of a randomly chosen shape.
    task automatic build_record(ref byte_t rec [$]);
        int    kind;
        int    start;
        int    total;
        byte_t c;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            // One well-formed window, sometimes with a spoiled digit.
            add_filler(rec, $urandom_range(0, 8));
            add_window(rec, random_lat_hemi(), random_lon_hemi(), $urandom_range(0, 6) == 0);
            add_filler(rec, $urandom_range(0, 5));
        end
        else if (kind < 55)
        begin
            // Two windows in any hemisphere order; north must win.
            add_filler(rec, $urandom_range(0, 4));
            add_window(rec, random_lat_hemi(), random_lon_hemi(), $urandom_range(0, 5) == 0);
            add_filler(rec, $urandom_range(0, 4));
            add_window(rec, random_lat_hemi(), random_lon_hemi(), $urandom_range(0, 5) == 0);
            add_filler(rec, $urandom_range(0, 3));
        end
        else if (kind < 65)
        begin
            // Window cut short by the end of the record.
            add_filler(rec, $urandom_range(0, 6));
            add_window(rec, random_lat_hemi(), random_lon_hemi(), 1'b0);
            repeat ($urandom_range(1, 19))
                void'(rec.pop_back());
        end
        else if (kind < 75)
        begin
            // Near miss: wrong longitude mark or wrong latitude mark.
            add_filler(rec, $urandom_range(0, 6));
            start = rec.size();
            add_window(rec, random_lat_hemi(), random_lon_hemi(), 1'b0);
            if ($urandom_range(0, 1))
            begin
                do
                    c = byte_t'($urandom_range(0, 255));
                while (c == CH_W || c == CH_E);
                rec[start + 9] = c;
            end
            else
            begin
                do
                    c = byte_t'($urandom_range(0, 255));
                while (c == CH_N || c == CH_S);
                rec[start] = c;
            end
            add_filler(rec, $urandom_range(0, 4));
        end
        else if (kind < 88)
        begin
            // Raw noise over the full byte range.
            repeat ($urandom_range(1, 30))
                rec.insert(rec.size(), byte_t'($urandom_range(0, 255)));
        end
        else if (kind < 93)
        begin
            // Overlong record with a window near the length limit.
            add_filler(rec, $urandom_range(135, 145));
            add_window(rec, random_lat_hemi(), random_lon_hemi(), 1'b0);
            total = $urandom_range(161, 200);
            if (rec.size() < total)
                add_filler(rec, total - rec.size());
        end
        else
        begin
            rec.insert(rec.size(), byte_t'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        byte_t rec [$];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a one-byte record with no window, then the largest
        // north/west coordinates in a record exactly one window long.
        rec.insert(rec.size(), 8'hFF);
        send_record(rec, 1'b0);
        rec.delete();
        rec.insert(rec.size(), CH_N);
        repeat (8) rec.insert(rec.size(), CH_9);
        rec.insert(rec.size(), CH_W);
        repeat (9) rec.insert(rec.size(), CH_9);
        rec.insert(rec.size(), 8'h00);
        send_record(rec, 1'b1);
        drain();

        // Random records, with a back-pressure burst part way through.
        while (sent_items < TARGET_ITEMS || sent_records < MIN_RECORDS)
        begin
            if (sent_records == 12)
            begin
                hold_req <= 1'b1;
                repeat (12)
                begin
                    rec.delete();
                    repeat ($urandom_range(1, 3))
                        rec.insert(rec.size(), byte_t'($urandom_range(0, 255)));
                    send_record(rec, 1'b1);
                end
                rec.delete();
                add_window(rec, random_lat_hemi(), random_lon_hemi(), 1'b0);
                add_filler(rec, 1);
                send_record(rec, 1'b1);
                drain();
            end
            rec.delete();
            build_record(rec);
            send_record(rec, $urandom_range(0, 3) == 0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
